/* src/input_restricted_deque_defines.svh */
// Assertion macros for the deque block.
// Each macro assumes clk and rst_n are visible in the enclosing module.
`ifndef INPUT_RESTRICTED_DEQUE_DEFINES_SVH
`define INPUT_RESTRICTED_DEQUE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset
`define IDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a trigger is followed by a condition in the next cycle
`define IDQ_ASSERT_NXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);
`else
`define IDQ_ASSERT(label, prop, msg)
`define IDQ_ASSERT_NXT(label, trig, prop, msg)
`endif
`endif

/* src/idq_pkg.sv */
`default_nettype none

package idq_pkg;

  // Ring geometry
  localparam int DEPTH = 8;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  // Command codes
  localparam logic [1:0] CMD_INSERT    = 2'd0;
  localparam logic [1:0] CMD_DEL_REAR  = 2'd1;
  localparam logic [1:0] CMD_DEL_FRONT = 2'd2;
  localparam logic [1:0] CMD_TRAVERSE  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  // Decoded command as it leaves the front queue
  typedef struct packed {
    logic               ins;
    logic               del_rear;
    logic               del_front;
    logic               trav;
    logic signed [31:0] value;
  } work_t;

  // Front-to-back handshake
  typedef struct packed {
    logic  valid;
    work_t work;
  } work_ch_t;

endpackage

`default_nettype wire

/* src/idq_front.sv */
`default_nettype none

module idq_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire idq_pkg::in_item_t in_item,
  output idq_pkg::work_ch_t     work_ch,
  input  wire logic             work_pop
);
  import idq_pkg::*;

  work_t      q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  work_t      dec;

  // Decode the command into one-hot flags
  always_comb begin
    dec          = '0;
    dec.value    = in_item.value;
    unique case (in_item.cmd)
      CMD_INSERT:    dec.ins       = 1'b1;
      CMD_DEL_REAR:  dec.del_rear  = 1'b1;
      CMD_DEL_FRONT: dec.del_front = 1'b1;
      CMD_TRAVERSE:  dec.trav      = 1'b1;
      default:       dec.trav      = 1'b1;
    endcase
  end

  assign in_full = (cnt_r == 2'd2);
  assign push    = in_push && !in_full;
  assign pop     = work_pop && (cnt_r != 2'd0);

  assign work_ch.valid = (cnt_r != 2'd0);
  assign work_ch.work  = q_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold the queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

`default_nettype wire

/* src/idq_back.sv */
`default_nettype none
`include "input_restricted_deque_defines.svh"

module idq_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire idq_pkg::work_ch_t work_ch,
  output logic                   work_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output idq_pkg::out_item_t     out_item
);
  import idq_pkg::*;

  localparam logic          S_IDLE   = 1'b0;
  localparam logic          S_EMIT   = 1'b1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  // Ring storage and its pointers
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;
  logic               state_r, state_nxt;
  logic               wr_en, rd_en;
  logic [AW-1:0]      rd_addr;

  // Result queue
  out_item_t  rq_r [2];
  logic       rq_wr_r, rq_rd_r;
  logic [1:0] rq_cnt_r;
  logic       rq_push, rq_pop, rq_space;
  out_item_t  res;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? LAST_IDX : p - AW'(1);
  endfunction

  assign rq_space  = (rq_cnt_r != 2'd2);
  assign rq_pop    = out_pop && (rq_cnt_r != 2'd0);
  assign out_empty = (rq_cnt_r == 2'd0);
  assign out_item  = rq_r[rq_rd_r];

  // Sequence one command at a time
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    state_nxt = state_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    work_pop  = 1'b0;
    rq_push   = 1'b0;
    res       = '{data: '0, status: ST_OK, last: 1'b1};
    unique case (state_r)
      S_IDLE: begin
        if (work_ch.valid && rq_space) begin
          work_pop = 1'b1;
          priority if (work_ch.work.ins) begin
            rq_push = 1'b1;
            if (fill_r == FULL_CNT) begin
              res.status = ST_OVERFLOW;
            end else begin
              wr_en    = 1'b1;
              tail_nxt = ptr_inc(tail_r);
              fill_nxt = fill_r + ONE_CNT;
            end
          end else if (fill_r == '0) begin
            // any removal or walk on an empty ring
            rq_push    = 1'b1;
            res.status = ST_EMPTY;
          end else if (work_ch.work.del_rear) begin
            rd_en     = 1'b1;
            rd_addr   = ptr_dec(tail_r);
            tail_nxt  = ptr_dec(tail_r);
            fill_nxt  = fill_r - ONE_CNT;
            rem_nxt   = ONE_CNT;
            state_nxt = S_EMIT;
          end else if (work_ch.work.del_front) begin
            rd_en     = 1'b1;
            rd_addr   = head_r;
            head_nxt  = ptr_inc(head_r);
            fill_nxt  = fill_r - ONE_CNT;
            rem_nxt   = ONE_CNT;
            state_nxt = S_EMIT;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = head_r;
            pos_nxt   = ptr_inc(head_r);
            rem_nxt   = fill_r;
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (rq_space) begin
          rq_push  = 1'b1;
          res.data = rd_data_r;
          res.last = (rem_r == ONE_CNT);
          rem_nxt  = rem_r - ONE_CNT;
          if (rem_r == ONE_CNT) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_r;
            pos_nxt = ptr_inc(pos_r);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      fill_r   <= '0;
      pos_r    <= '0;
      rem_r    <= '0;
      rq_wr_r  <= 1'b0;
      rq_rd_r  <= 1'b0;
      rq_cnt_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
      pos_r    <= pos_nxt;
      rem_r    <= rem_nxt;
      rq_wr_r  <= rq_push ? ~rq_wr_r : rq_wr_r;
      rq_rd_r  <= rq_pop ? ~rq_rd_r : rq_rd_r;
      rq_cnt_r <= rq_cnt_r + {1'b0, rq_push} - {1'b0, rq_pop};
    end
  end

  // Write and read the ring, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= work_ch.work.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Hold waiting results
  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_r[rq_wr_r] <= res;
    end
  end

  `IDQ_ASSERT(a_fill_bound, fill_r <= FULL_CNT, "fill count beyond ring depth")
  `IDQ_ASSERT(a_empty_ptrs, (fill_r != '0) || (head_r == tail_r), "empty ring with split pointers")
  `IDQ_ASSERT(a_emit_rem, (state_r != S_EMIT) || (rem_r != '0), "emitting with nothing left")
  `IDQ_ASSERT(a_rq_bound, rq_cnt_r <= 2'd2, "result queue overrun")
  `IDQ_ASSERT_NXT(a_emit_rd, (state_r == S_IDLE) && rd_en, state_r == S_EMIT, "read without emit")

endmodule

`default_nettype wire

/* src/input_restricted_deque.sv */
// Path: an insert or empty-ring result goes from the front queue to the result queue;
// a delete first passes through the registered ring read. While the result queue has
// space the deque takes one insert per cycle and a walk emits one value per cycle after
// the first ring read; a delete holds the back end until its value is emitted.
// Reset: synchronous, active low; clears pointers, fill count and both queues.
// Slot contents are not cleared.
`default_nettype none

module input_restricted_deque (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire idq_pkg::in_item_t  in_item,
  output logic                    empty,
  input  wire logic               pop,
  output idq_pkg::out_item_t      out_item
);
  import idq_pkg::*;

  work_ch_t work_ch;
  logic     work_pop;

  // Accept and decode commands
  idq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (push),
    .in_full  (full),
    .in_item  (in_item),
    .work_ch  (work_ch),
    .work_pop (work_pop)
  );

  // Carry out commands on the ring
  idq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .work_ch   (work_ch),
    .work_pop  (work_pop),
    .out_empty (empty),
    .out_pop   (pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
